@@ design/ccsdm_pkg.sv @@
// Shared types, constants and angle table for the concentric disk mapping pipeline.
package ccsdm_pkg;

    localparam int FIELD_W = 16;
    localparam int RAD_W   = 17;

    localparam logic [1:0] OCT_EAST  = 2'd0;
    localparam logic [1:0] OCT_NORTH = 2'd1;
    localparam logic [1:0] OCT_WEST  = 2'd2;
    localparam logic [1:0] OCT_SOUTH = 2'd3;

    localparam logic [29:0] PI4_Q30  = 30'd843314857;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    localparam logic [FIELD_W-1:0] DISK_CENTER = 16'd32768;
    localparam logic [FIELD_W-1:0] DISK_MAX    = 16'd65535;

    localparam logic [31:0] ATAN_Q30 [30] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h00100000, 32'h00080000, 32'h00040000, 32'h00020000, 32'h00010000,
        32'h00008000, 32'h00004000, 32'h00002000, 32'h00001000, 32'h00000800,
        32'h00000400, 32'h00000200, 32'h00000100, 32'h00000080, 32'h00000040,
        32'h00000020, 32'h00000010, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef struct packed {
        logic [FIELD_W-1:0] sample_u;
        logic [FIELD_W-1:0] sample_v;
        logic               end_of_set;
    } sample_t;

    typedef struct packed {
        logic [FIELD_W-1:0] disk_x;
        logic [FIELD_W-1:0] disk_y;
        logic               end_of_set_out;
    } result_t;

    typedef struct packed {
        logic             center;
        logic             eos;
        logic [1:0]       octant;
        logic             neg;
        logic [RAD_W-1:0] radius;
    } div_side_t;

    typedef struct packed {
        logic       center;
        logic       eos;
        logic [1:0] quadrant;
    } cord_tag_t;

    function automatic logic [31:0] atan_q(input int step, input int frac);
        logic [32:0] sum;
        begin
            sum = 33'(ATAN_Q30[step]);
            if (frac >= 30)
            begin
                atan_q = sum[31:0];
            end
            else
            begin
                sum = (sum + (33'd1 << (29 - frac))) >> (30 - frac);
                atan_q = sum[31:0];
            end
        end
    endfunction

endpackage

@@ design/ccsdm_div_cell.sv @@
// One restoring division cell: resolves one quotient bit per cycle.
module ccsdm_div_cell
    import ccsdm_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int BIT_POS   = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    input  logic [FRAC_BITS+18:0]  up_rem,
    input  logic [FRAC_BITS:0]     up_quot,
    input  div_side_t              up_side,
    output logic                   dn_valid,
    output logic [FRAC_BITS+18:0]  dn_rem,
    output logic [FRAC_BITS:0]     dn_quot,
    output div_side_t              dn_side
);
    localparam int QW = FRAC_BITS + 1;
    localparam int RW = FRAC_BITS + 19;

    logic          valid_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quot_reg, quot_next;
    div_side_t     side_reg;
    logic [RW-1:0] cmp;
    logic          fit;

    always_comb
    begin
        cmp       = RW'(up_side.radius) << BIT_POS;
        fit       = (up_rem >= cmp);
        rem_next  = fit ? (up_rem - cmp) : up_rem;
        quot_next = {up_quot[QW-2:0], fit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        side_reg <= up_side;
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_quot  = quot_reg;
    assign dn_side  = side_reg;
endmodule

@@ design/ccsdm_cordic_cell.sv @@
// One CORDIC rotation cell with its fixed shift and angle constant.
module ccsdm_cordic_cell
    import ccsdm_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int STEP      = 0
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    input  logic signed [FRAC_BITS+2:0]  up_x,
    input  logic signed [FRAC_BITS+2:0]  up_y,
    input  logic signed [FRAC_BITS+2:0]  up_z,
    input  cord_tag_t                    up_tag,
    output logic                         dn_valid,
    output logic signed [FRAC_BITS+2:0]  dn_x,
    output logic signed [FRAC_BITS+2:0]  dn_y,
    output logic signed [FRAC_BITS+2:0]  dn_z,
    output cord_tag_t                    dn_tag
);
    localparam int W = FRAC_BITS + 3;
    localparam logic signed [W-1:0] ANG = W'(atan_q(STEP, FRAC_BITS));

    logic                valid_reg;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] y_reg, y_next;
    logic signed [W-1:0] z_reg, z_next;
    cord_tag_t           tag_reg;
    logic signed [W-1:0] dx, dy;

    always_comb
    begin
        dx = up_y >>> STEP;
        dy = up_x >>> STEP;
        if (!up_z[W-1])
        begin
            x_next = up_x - dx;
            y_next = up_y + dy;
            z_next = up_z - ANG;
        end
        else
        begin
            x_next = up_x + dx;
            y_next = up_y - dy;
            z_next = up_z + ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        tag_reg <= up_tag;
    end

    assign dn_valid = valid_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_z     = z_reg;
    assign dn_tag   = tag_reg;
endmodule

@@ design/concentric_square_to_disk_map_unit.sv @@
// Top level of the concentric square-to-disk sample mapping pipeline.
//
// Usage:
//   Drive sample (u, v, end_of_set) with start high; the transaction is taken
//   at that clock edge. busy is always low, so one transaction can enter
//   every cycle and many are in flight at once.
//   Each result appears on result for exactly one cycle with done high,
//   in the same order as the samples went in.
//   Each sample passes through the chain of FRAC_BITS+1 divider cells,
//   stage A, stage B, the chain of CORDIC_STEPS rotation cells and the
//   output register, in that order. Throughput is one sample per cycle.
//   The receiver cannot stall: a result not taken in its cycle is gone.
//   Reset clears every stage's valid flag; anything in flight is dropped.
//   The exact center of the square maps to (32768, 32768).
module concentric_square_to_disk_map_unit
    import ccsdm_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  sample_t sample,
    output logic    done,
    output result_t result
);
    localparam int QW  = FRAC_BITS + 1;
    localparam int RW  = FRAC_BITS + 19;
    localparam int W   = FRAC_BITS + 3;
    localparam int WW  = FRAC_BITS + 5;
    localparam int PW  = FRAC_BITS + 2;
    localparam int ZPW = FRAC_BITS + 31;
    localparam int RPW = 47;
    localparam int OW  = FRAC_BITS + 11;
    localparam int OSH = FRAC_BITS - 15;
    localparam logic signed [WW-1:0] ONE   = WW'(1) <<< FRAC_BITS;
    localparam logic signed [PW-1:0] ONE_P = PW'(1) <<< FRAC_BITS;

    // front: recenter and pick octant
    logic signed [17:0] x, y, nx, ny, num;
    logic [1:0]         oct;
    logic [RAD_W-1:0]   rad, mag;
    div_side_t          f_side;
    logic [RW-1:0]      f_rem;

    always_comb
    begin
        x  = $signed({1'b0, sample.sample_u, 1'b0}) - 18'sd65536;
        y  = $signed({1'b0, sample.sample_v, 1'b0}) - 18'sd65536;
        nx = -x;
        ny = -y;
        if (x > ny)
        begin
            if (x > y)
            begin
                oct = OCT_EAST;
                rad = x[16:0];
                num = y;
            end
            else
            begin
                oct = OCT_NORTH;
                rad = y[16:0];
                num = x;
            end
        end
        else
        begin
            if (x < y)
            begin
                oct = OCT_WEST;
                rad = nx[16:0];
                num = y;
            end
            else
            begin
                oct = OCT_SOUTH;
                rad = ny[16:0];
                num = x;
            end
        end
        mag = num[17] ? 17'(-num) : num[16:0];
        f_side.center = (x == 18'sd0) && (y == 18'sd0);
        f_side.eos    = sample.end_of_set;
        f_side.octant = oct;
        f_side.neg    = num[17];
        f_side.radius = rad;
        f_rem = (RW'(mag) << FRAC_BITS) + RW'(rad[16:1]);
    end

    // divider chain
    logic          d_valid [0:QW];
    logic [RW-1:0] d_rem   [0:QW];
    logic [QW-1:0] d_quot  [0:QW];
    div_side_t     d_side  [0:QW];

    assign d_valid[0] = start;
    assign d_rem[0]   = f_rem;
    assign d_quot[0]  = '0;
    assign d_side[0]  = f_side;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        ccsdm_div_cell #(
            .FRAC_BITS (FRAC_BITS),
            .BIT_POS   (FRAC_BITS - j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (d_valid[j]),
            .up_rem   (d_rem[j]),
            .up_quot  (d_quot[j]),
            .up_side  (d_side[j]),
            .dn_valid (d_valid[j+1]),
            .dn_rem   (d_rem[j+1]),
            .dn_quot  (d_quot[j+1]),
            .dn_side  (d_side[j+1])
        );
    end

    // stage A: angle, quadrant and residual
    logic signed [WW-1:0] qs, ang, w;
    logic signed [PW-1:0] phi;
    logic [QW-1:0]        phi_mag_next;
    logic                 a_valid_reg;
    logic [QW-1:0]        a_mag_reg;
    logic                 a_neg_reg;
    logic [1:0]           a_quad_reg;
    div_side_t            a_side_reg;
    div_side_t            ls;

    always_comb
    begin
        ls = d_side[QW];
        qs = $signed(WW'(d_quot[QW]));
        if (ls.neg)
        begin
            qs = -qs;
        end
        case (ls.octant)
            OCT_EAST:  ang = qs;
            OCT_NORTH: ang = (ONE <<< 1) - qs;
            OCT_WEST:  ang = (ONE <<< 2) - qs;
            OCT_SOUTH: ang = (ONE <<< 2) + (ONE <<< 1) + qs;
            default:   ang = qs;
        endcase
        w = ang + ONE;
        if (w[WW-1])
        begin
            w = '0;
        end
        phi = $signed({1'b0, w[FRAC_BITS:0]}) - ONE_P;
        phi_mag_next = phi[PW-1] ? QW'(-phi) : QW'(phi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= d_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg  <= phi_mag_next;
        a_neg_reg  <= phi[PW-1];
        a_quad_reg <= w[FRAC_BITS+2:FRAC_BITS+1];
        a_side_reg <= ls;
    end

    // stage B: angle scaling and gain products
    logic           b_valid_reg;
    logic [ZPW-1:0] b_pz_reg;
    logic [RPW-1:0] b_pr_reg;
    logic           b_neg_reg;
    cord_tag_t      b_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_pz_reg           <= ZPW'(a_mag_reg) * ZPW'(PI4_Q30);
        b_pr_reg           <= RPW'(a_side_reg.radius) * RPW'(GAIN_Q30);
        b_neg_reg          <= a_neg_reg;
        b_tag_reg.center   <= a_side_reg.center;
        b_tag_reg.eos      <= a_side_reg.eos;
        b_tag_reg.quadrant <= a_quad_reg;
    end

    // stage C: round into CORDIC start values
    logic [ZPW:0]        z_sum;
    logic [RPW:0]        r_sum;
    logic signed [W-1:0] z0, x0;

    always_comb
    begin
        z_sum = (ZPW+1)'(b_pz_reg) + ((ZPW+1)'(1) << 29);
        z_sum = z_sum >> 30;
        z0    = $signed(W'(z_sum[QW-1:0]));
        if (b_neg_reg)
        begin
            z0 = -z0;
        end
        r_sum = (RPW+1)'(b_pr_reg) + ((RPW+1)'(1) << (45 - FRAC_BITS));
        r_sum = r_sum >> (46 - FRAC_BITS);
        x0    = $signed(r_sum[W-1:0]);
    end

    // CORDIC chain
    logic                c_valid [0:CORDIC_STEPS];
    logic signed [W-1:0] c_x     [0:CORDIC_STEPS];
    logic signed [W-1:0] c_y     [0:CORDIC_STEPS];
    logic signed [W-1:0] c_z     [0:CORDIC_STEPS];
    cord_tag_t           c_tag   [0:CORDIC_STEPS];

    assign c_valid[0] = b_valid_reg;
    assign c_x[0]     = x0;
    assign c_y[0]     = '0;
    assign c_z[0]     = z0;
    assign c_tag[0]   = b_tag_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        ccsdm_cordic_cell #(
            .FRAC_BITS (FRAC_BITS),
            .STEP      (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (c_valid[i]),
            .up_x     (c_x[i]),
            .up_y     (c_y[i]),
            .up_z     (c_z[i]),
            .up_tag   (c_tag[i]),
            .dn_valid (c_valid[i+1]),
            .dn_x     (c_x[i+1]),
            .dn_y     (c_y[i+1]),
            .dn_z     (c_z[i+1]),
            .dn_tag   (c_tag[i+1])
        );
    end

    // output stage: quadrant swap, scale, saturate, center override
    logic signed [W-1:0]  cc, ss;
    logic signed [OW-1:0] tc, ts, oc, os;
    logic [FIELD_W-1:0]   dx_next, dy_next;
    logic                 done_reg;
    result_t              result_reg;
    cord_tag_t            lt;

    always_comb
    begin
        lt = c_tag[CORDIC_STEPS];
        case (lt.quadrant)
            2'd0:
            begin
                cc = c_x[CORDIC_STEPS];
                ss = c_y[CORDIC_STEPS];
            end
            2'd1:
            begin
                cc = -c_y[CORDIC_STEPS];
                ss = c_x[CORDIC_STEPS];
            end
            2'd2:
            begin
                cc = -c_x[CORDIC_STEPS];
                ss = -c_y[CORDIC_STEPS];
            end
            default:
            begin
                cc = c_y[CORDIC_STEPS];
                ss = -c_x[CORDIC_STEPS];
            end
        endcase
    end

    if (OSH > 0)
    begin : g_round
        assign tc = (OW'(cc) + (OW'(1) <<< (OSH - 1))) >>> OSH;
        assign ts = (OW'(ss) + (OW'(1) <<< (OSH - 1))) >>> OSH;
    end
    else
    begin : g_widen
        assign tc = OW'(cc) <<< (-OSH);
        assign ts = OW'(ss) <<< (-OSH);
    end

    always_comb
    begin
        oc = tc + OW'(32768);
        os = ts + OW'(32768);
        if (oc < 0)
        begin
            dx_next = '0;
        end
        else if (oc > OW'(65535))
        begin
            dx_next = DISK_MAX;
        end
        else
        begin
            dx_next = oc[FIELD_W-1:0];
        end
        if (os < 0)
        begin
            dy_next = '0;
        end
        else if (os > OW'(65535))
        begin
            dy_next = DISK_MAX;
        end
        else
        begin
            dy_next = os[FIELD_W-1:0];
        end
        if (lt.center)
        begin
            dx_next = DISK_CENTER;
            dy_next = DISK_CENTER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.disk_x         <= dx_next;
        result_reg.disk_y         <= dy_next;
        result_reg.end_of_set_out <= lt.eos;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;
endmodule

@@ design/ccsdm_checker.sv @@
// Port-level checks for the disk mapping unit, bound to the top level.
module ccsdm_checker
    import ccsdm_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input sample_t sample,
    input logic    done,
    input result_t result
);
    localparam int LAT = FRAC_BITS + CORDIC_STEPS + 4;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("transaction result missing");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without transaction");

    a_eos_pass: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT (result.end_of_set_out == $past(sample.end_of_set, LAT)))
        else $error("end of set flag mismatch");

    a_center: assert property (@(posedge clk) disable iff (!rst_n)
        (start && sample.sample_u == DISK_CENTER && sample.sample_v == DISK_CENTER)
        |-> ##LAT (result.disk_x == DISK_CENTER && result.disk_y == DISK_CENTER))
        else $error("center sample not mapped to center");
endmodule

bind concentric_square_to_disk_map_unit ccsdm_checker #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
) u_ccsdm_checker (.*);

@@ tb/concentric_square_to_disk_map_checker.sv @@
// Checker that predicts each mapped disk point and compares it with the block's results.
module concentric_square_to_disk_map_checker
    import ccsdm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  sample_t sample,
    input  logic    done,
    input  result_t result,
    output int      mismatches,
    output int      points_waiting,
    output int      points_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB    = 16;
    localparam int STEPS = 16;

    result_t expected_points[$];
    int      fail_count  = 0;
    int      check_count = 0;

    assign mismatches     = fail_count;
    assign points_waiting = expected_points.size();
    assign points_checked = check_count;

    function automatic longint div_round(longint num, longint den);
        longint mag;
        longint q;
        begin
            mag = (num < 0) ? -num : num;
            q = ((mag << FB) + den / 2) / den;
            div_round = (num < 0) ? -q : q;
        end
    endfunction

    function automatic logic [15:0] to_disk(longint v);
        longint o;
        begin
            o = ((v + 1) >>> 1) + 32768;
            if (o < 0)
            begin
                o = 0;
            end
            if (o > 65535)
            begin
                o = 65535;
            end
            to_disk = o[15:0];
        end
    endfunction

    function automatic result_t map_to_disk(sample_t s);
        longint  one;
        longint  x;
        longint  y;
        longint  r;
        longint  ang;
        longint  w;
        longint  phi;
        longint  z;
        longint  m;
        longint  cx;
        longint  cy;
        longint  c;
        longint  sn;
        longint  a;
        longint  dx;
        longint  dy;
        longint  k;
        result_t p;
        begin
            one = 64'sd1 << FB;
            x = 2 * longint'(s.sample_u) - 65536;
            y = 2 * longint'(s.sample_v) - 65536;
            p.end_of_set_out = s.end_of_set;
            if (x == 0 && y == 0)
            begin
                p.disk_x = DISK_CENTER;
                p.disk_y = DISK_CENTER;
                return p;
            end
            if (x > -y)
            begin
                if (x > y)
                begin
                    r = x;
                    ang = div_round(y, x);
                end
                else
                begin
                    r = y;
                    ang = 2 * one - div_round(x, y);
                end
            end
            else
            begin
                if (x < y)
                begin
                    r = -x;
                    ang = 4 * one - div_round(y, -x);
                end
                else
                begin
                    r = -y;
                    ang = 6 * one + div_round(x, -y);
                end
            end
            w = ang + one;
            if (w < 0)
            begin
                w = 0;
            end
            k = w >>> (FB + 1);
            phi = w - (k << (FB + 1)) - one;
            m = (phi < 0) ? -phi : phi;
            m = (m * longint'(PI4_Q30) + (64'sd1 << 29)) >>> 30;
            z = (phi < 0) ? -m : m;
            cx = (r * longint'(GAIN_Q30) + (64'sd1 << (45 - FB))) >>> (46 - FB);
            cy = 0;
            for (int i = 0; i < STEPS; i++)
            begin
                a = (longint'(ATAN_Q30[i]) + (64'sd1 << (29 - FB))) >>> (30 - FB);
                dx = cy >>> i;
                dy = cx >>> i;
                if (z >= 0)
                begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z = z - a;
                end
                else
                begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z = z + a;
                end
            end
            case (k[1:0])
                OCT_EAST:
                begin
                    c = cx;
                    sn = cy;
                end
                OCT_NORTH:
                begin
                    c = -cy;
                    sn = cx;
                end
                OCT_WEST:
                begin
                    c = -cx;
                    sn = -cy;
                end
                default:
                begin
                    c = cy;
                    sn = -cx;
                end
            endcase
            p.disk_x = to_disk(c);
            p.disk_y = to_disk(sn);
            return p;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t exp_point;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_points.insert(expected_points.size(), map_to_disk(sample));
            end
            if (done)
            begin
                if (expected_points.size() == 0)
                begin
                    fail_count++;
                    $display("%t: unexpected result x=%0d y=%0d eos=%0d", $time,
                             result.disk_x, result.disk_y, result.end_of_set_out);
                end
                else
                begin
                    exp_point = expected_points.pop_front();
                    check_count++;
                    if (result.disk_x !== exp_point.disk_x)
                    begin
                        fail_count++;
                        $display("%t: disk_x expected %0d actual %0d", $time,
                                 exp_point.disk_x, result.disk_x);
                    end
                    if (result.disk_y !== exp_point.disk_y)
                    begin
                        fail_count++;
                        $display("%t: disk_y expected %0d actual %0d", $time,
                                 exp_point.disk_y, result.disk_y);
                    end
                    if (result.end_of_set_out !== exp_point.end_of_set_out)
                    begin
                        fail_count++;
                        $display("%t: end_of_set_out expected %0d actual %0d", $time,
                                 exp_point.end_of_set_out, result.end_of_set_out);
                    end
                end
            end
        end
    end

endmodule

@@ tb/concentric_square_to_disk_map_unit_tb.sv @@
// Testbench top: drives samples into the disk mapping unit and reports the verdict.
module concentric_square_to_disk_map_unit_tb
    import ccsdm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    sample_t sample = '0;
    logic    done;
    result_t result;
    int      mismatches;
    int      points_waiting;
    int      points_checked;
    int      idle_pct = 0;
    int      samples_sent = 0;
    int      quiet_cycles = 0;

    always #2 clk = ~clk;

    concentric_square_to_disk_map_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .sample (sample),
        .done   (done),
        .result (result)
    );

    concentric_square_to_disk_map_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .sample         (sample),
        .done           (done),
        .result         (result),
        .mismatches     (mismatches),
        .points_waiting (points_waiting),
        .points_checked (points_checked)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_sample(input logic [15:0] u, input logic [15:0] v, input logic eos);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start <= 1'b1;
            sample <= '{sample_u: u, sample_v: v, end_of_set: eos};
            @(posedge clk);
            while (busy)
            begin
                @(posedge clk);
            end
            samples_sent++;
        end
    endtask

    task automatic drain;
        begin
            start <= 1'b0;
            @(posedge clk);
            while (points_waiting != 0)
            begin
                @(posedge clk);
            end
        end
    endtask

    task automatic send_random;
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] d;
        begin
            u = 16'($urandom);
            v = 16'($urandom);
            d = 16'($urandom_range(0, 40));
            case ($urandom_range(0, 5))
                0: ;
                1:
                begin
                    u = 16'(32768 + $urandom_range(0, 8) - 4);
                    v = 16'(32768 + $urandom_range(0, 8) - 4);
                end
                2: v = u + 16'($urandom_range(0, 2)) - 16'd1;
                3: v = 16'(65536 - u) + 16'($urandom_range(0, 2)) - 16'd1;
                4:
                begin
                    u = $urandom_range(1) ? d : 16'(65535 - d);
                end
                default:
                begin
                    v = $urandom_range(1) ? d : 16'(65535 - d);
                end
            endcase
            send_sample(u, v, 1'($urandom));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'd0, 16'd0, 1'b0);
        send_sample(16'd65535, 16'd65535, 1'b1);
        send_sample(16'd0, 16'd65535, 1'b0);
        send_sample(16'd65535, 16'd0, 1'b1);
        send_sample(16'd32768, 16'd32768, 1'b1);
        send_sample(16'd32768, 16'd32768, 1'b0);
        send_sample(16'd32769, 16'd32768, 1'b0);
        send_sample(16'd32767, 16'd32768, 1'b0);
        send_sample(16'd32768, 16'd32769, 1'b0);
        send_sample(16'd32768, 16'd32767, 1'b0);
        send_sample(16'd40000, 16'd40000, 1'b0);
        send_sample(16'd20000, 16'd20000, 1'b1);
        send_sample(16'd20000, 16'd45536, 1'b0);
        send_sample(16'd45536, 16'd20000, 1'b0);
        send_sample(16'd65535, 16'd32768, 1'b0);
        send_sample(16'd0, 16'd32768, 1'b0);
        send_sample(16'd32768, 16'd65535, 1'b0);
        send_sample(16'd32768, 16'd0, 1'b0);
        send_sample(16'h5555, 16'hAAAA, 1'b1);
        send_sample(16'hAAAA, 16'h5555, 1'b0);
        send_sample(16'd65535, 16'd65534, 1'b0);
        send_sample(16'd1, 16'd0, 1'b1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 80;
                3:       idle_pct = 16;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 310; n++)
            begin
                send_random();
            end
            drain();
        end
        idle_pct = 0;

        repeat (FIELD_W + 16 + 12) @(posedge clk);
        $display("Covered %0d samples: square corners, edges, center, diagonals, random.",
                 samples_sent);
        $display("Checked %0d mapped points with idle gaps of 0, 16 and 80 percent.",
                 points_checked);
        if (mismatches == 0 && points_waiting == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
